// ===== sv/mhpr_pkg.sv =====
// Shared types and constants for the min-heap packet reorder block.
// Used by mhpr_cell, mhpr_ctrl and min_heap_packet_reorder; no dependencies.
`default_nettype none

package mhpr_pkg;

  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] BLOCK_SIZE_RST = 6'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_RD,
    ST_POP_CHK,
    ST_LAST_RD,
    ST_LAST_DAT,
    ST_DN_RD,
    ST_DN_CMP
  } state_t;

  // Command broadcast from the controller to the level cells.
  typedef struct packed {
    logic rd;
    logic wr;
    logic wr_side;  // 0: left (even position) half of a row, 1: right half
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/min_heap_packet_reorder.sv =====
// Top level of the min-heap packet reorder buffer: controller plus a chain of level cells.
// Depends on mhpr_pkg, mhpr_cell and mhpr_ctrl.
//
// Usage:
//  - Input: a packet transfer happens at a clock edge with start high and busy low.
//    Each packet is inserted into a binary min-heap keyed by in_seq_number.
//  - Every block_size packets (0 acts as 1), or on a packet with in_end_of_input set,
//    a release run pops the root while it equals the expected sequence number.
//  - Results: one cycle on out_* with out_valid high; the receiver cannot stall.
//    The last packet of a run has out_run_last set; a packet that finds the heap
//    full is dropped and reported once with out_overflow set.
//  - Config: cfg_we writes block_size (cfg_wdata); the user must do so only while the
//    block is idle, which the block does not enforce. One cell per tree level.
//  - Sequence: insert does a parent read and compare per parent, plus a root write
//    when the packet climbs that far. Each pop: root read, check, last entry read and
//    load, a child read and compare per level descended, then placing the moved entry;
//    popping the only entry needs just the root read and check. A run ends with a root
//    read and a failing check. A popped packet is held and shows on out_* after the next root check.
//  - Reset (rst_n low, synchronous): heap empty, expected number 0, block_size 8.
//    Heap entries are not cleared; values of unoccupied slots are never used.
`default_nettype none

module min_heap_packet_reorder #(
  parameter int HEAP_DEPTH = 32,
  parameter int SEQ_WIDTH  = 16,
  parameter int TAG_WIDTH  = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [SEQ_WIDTH-1:0]       in_seq_number,
  input  wire logic [TAG_WIDTH-1:0]       in_payload_tag,
  input  wire logic                       in_end_of_input,
  input  wire logic                       cfg_we,
  input  wire logic [mhpr_pkg::CFG_W-1:0] cfg_wdata,
  output logic                            out_valid,
  output logic [SEQ_WIDTH-1:0]            out_seq,
  output logic [TAG_WIDTH-1:0]            out_tag,
  output logic                            out_run_last,
  output logic                            out_overflow
);

  localparam int ENTRY_W = SEQ_WIDTH + TAG_WIDTH;
  localparam int LEVELS  = $clog2(HEAP_DEPTH + 1);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int ROW_W   = (LEVELS > 2) ? LEVELS - 2 : 1;

  mhpr_pkg::cell_cmd_t   cmd;
  logic [LVL_W-1:0]      lvl_sel;
  logic [ROW_W-1:0]      row;
  logic [ENTRY_W-1:0]    wdata;
  logic [2*ENTRY_W-1:0]  rd_chain [LEVELS+1];

  mhpr_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .SEQ_WIDTH  (SEQ_WIDTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_seq_number   (in_seq_number),
    .in_payload_tag  (in_payload_tag),
    .in_end_of_input (in_end_of_input),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_seq         (out_seq),
    .out_tag         (out_tag),
    .out_run_last    (out_run_last),
    .out_overflow    (out_overflow),
    .cmd             (cmd),
    .lvl_sel         (lvl_sel),
    .row             (row),
    .wdata           (wdata),
    .rd_data         (rd_chain[0])
  );

  assign rd_chain[LEVELS] = '0;

  // read data ripples from the deepest level toward the root cell
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    mhpr_cell #(
      .LEVEL   (k),
      .LVL_W   (LVL_W),
      .ROW_W   (ROW_W),
      .ENTRY_W (ENTRY_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .lvl_sel (lvl_sel),
      .row     (row),
      .wdata   (wdata),
      .rd_in   (rd_chain[k+1]),
      .rd_out  (rd_chain[k])
    );
  end

endmodule

`default_nettype wire

// ===== sv/mhpr_cell.sv =====
// One heap level: the entries of tree level LEVEL, stored as rows of sibling pairs (the root as one register).
// Depends on mhpr_pkg; chained so that read data passes from cell to cell.
`default_nettype none

module mhpr_cell #(
  parameter int LEVEL   = 0,
  parameter int LVL_W   = 1,
  parameter int ROW_W   = 1,
  parameter int ENTRY_W = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mhpr_pkg::cell_cmd_t    cmd,
  input  wire logic [LVL_W-1:0]       lvl_sel,
  input  wire logic [ROW_W-1:0]       row,
  input  wire logic [ENTRY_W-1:0]     wdata,
  input  wire logic [2*ENTRY_W-1:0]   rd_in,
  output logic      [2*ENTRY_W-1:0]   rd_out
);

  logic                 hit;
  logic                 sel_r;
  logic [2*ENTRY_W-1:0] rd_q_r;

  assign hit = (lvl_sel == LVL_W'(LEVEL));

  generate
    if (LEVEL == 0) begin : g_root
      logic [ENTRY_W-1:0] root_r;
      always_ff @(posedge clk) begin
        if (hit && cmd.wr) begin
          root_r <= wdata;
        end
        if (hit && cmd.rd) begin
          rd_q_r <= {root_r, root_r};
        end
      end
    end else if (LEVEL == 1) begin : g_pair
      logic [ENTRY_W-1:0] left_r;
      logic [ENTRY_W-1:0] right_r;
      always_ff @(posedge clk) begin
        if (hit && cmd.wr) begin
          if (cmd.wr_side) begin
            right_r <= wdata;
          end else begin
            left_r <= wdata;
          end
        end
        if (hit && cmd.rd) begin
          rd_q_r <= {left_r, right_r};
        end
      end
    end else begin : g_mem
      localparam int ROWS = 2 ** (LEVEL - 1);
      localparam int AW   = $clog2(ROWS);
      logic [ENTRY_W-1:0] mem_l [ROWS];
      logic [ENTRY_W-1:0] mem_r [ROWS];
      always_ff @(posedge clk) begin
        if (hit && cmd.wr) begin
          if (cmd.wr_side) begin
            mem_r[row[AW-1:0]] <= wdata;
          end else begin
            mem_l[row[AW-1:0]] <= wdata;
          end
        end
        if (hit && cmd.rd) begin
          rd_q_r <= {mem_l[row[AW-1:0]], mem_r[row[AW-1:0]]};
        end
      end
    end
  endgenerate

  // remember which level answered the last read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (cmd.rd) begin
      sel_r <= hit;
    end
  end

  assign rd_out = sel_r ? rd_q_r : rd_in;

endmodule

`default_nettype wire

// ===== sv/mhpr_ctrl.sv =====
// Heap controller: insert by sift-up, release runs by pop and sift-down.
// Depends on mhpr_pkg; drives the level cells of min_heap_packet_reorder.
`default_nettype none

module mhpr_ctrl #(
  parameter int HEAP_DEPTH = 32,
  parameter int SEQ_WIDTH  = 16,
  parameter int TAG_WIDTH  = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [SEQ_WIDTH-1:0]      in_seq_number,
  input  wire logic [TAG_WIDTH-1:0]      in_payload_tag,
  input  wire logic                      in_end_of_input,
  input  wire logic                      cfg_we,
  input  wire logic [mhpr_pkg::CFG_W-1:0] cfg_wdata,
  output logic                           out_valid,
  output logic [SEQ_WIDTH-1:0]           out_seq,
  output logic [TAG_WIDTH-1:0]           out_tag,
  output logic                           out_run_last,
  output logic                           out_overflow,
  output mhpr_pkg::cell_cmd_t            cmd,
  output logic [$clog2($clog2(HEAP_DEPTH+1))-1:0] lvl_sel,
  output logic [(($clog2(HEAP_DEPTH+1) > 2) ? $clog2(HEAP_DEPTH+1)-2 : 1)-1:0] row,
  output logic [SEQ_WIDTH+TAG_WIDTH-1:0] wdata,
  input  wire logic [2*(SEQ_WIDTH+TAG_WIDTH)-1:0] rd_data
);

  localparam int ENTRY_W = SEQ_WIDTH + TAG_WIDTH;
  localparam int LEVELS  = $clog2(HEAP_DEPTH + 1);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int ROW_W   = (LEVELS > 2) ? LEVELS - 2 : 1;
  localparam int CW      = LEVELS;
  localparam int NW      = LEVELS + 1;
  localparam int CFG_W   = mhpr_pkg::CFG_W;

  mhpr_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic [SEQ_WIDTH-1:0] exp_r, exp_nxt;
  logic [CFG_W-1:0]     fill_r, fill_nxt;
  logic [CFG_W-1:0]     bsize_r;
  logic [ENTRY_W-1:0]   item_r, item_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  logic                 rel_r, rel_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [ENTRY_W-1:0]   pend_r, pend_nxt;

  logic                 ov_r, ov_nxt;
  logic [ENTRY_W-1:0]   oent_r, oent_nxt;
  logic                 olast_r, olast_nxt;
  logic                 oovf_r, oovf_nxt;

  function automatic logic [LVL_W-1:0] msb_of(input logic [NW-1:0] v);
    logic [LVL_W-1:0] res;
    res = '0;
    for (int i = 0; i < NW; i++) begin
      if (v[i]) res = LVL_W'(i);
    end
    return res;
  endfunction

  // shared decisions
  logic                 accept, full, rel_now;
  logic [CFG_W-1:0]     fill_inc, bs;
  logic [NW-1:0]        p_cur, n_par, p_par;
  logic [ROW_W-1:0]     row_cur, row_par, row_ch;
  logic                 side_cur, side_par;
  logic [ENTRY_W-1:0]   rd_l, rd_r, par_ent;
  logic                 n_is_root, up_less, pop_hit, dn_leaf, r_ok, pick_l, pick_r;
  logic [SEQ_WIDTH-1:0] best_key;
  logic [CW-1:0]        count_inc;

  assign accept    = start && (state_r == mhpr_pkg::ST_IDLE);
  assign busy      = (state_r != mhpr_pkg::ST_IDLE);
  assign full      = (count_r == CW'(HEAP_DEPTH));
  assign fill_inc  = fill_r + CFG_W'(1);
  assign bs        = (bsize_r == '0) ? CFG_W'(1) : bsize_r;
  assign rel_now   = (fill_inc >= bs) || in_end_of_input;
  assign count_inc = count_r + CW'(1);

  // 1-based node index n at level k sits at position n ^ 2^k of that level
  assign p_cur    = n_r ^ (NW'(1) << lvl_r);
  assign row_cur  = ROW_W'(p_cur >> 1);
  assign side_cur = p_cur[0];
  assign n_par    = n_r >> 1;
  assign p_par    = n_par ^ (NW'(1) << (lvl_r - 1'b1));
  assign row_par  = ROW_W'(p_par >> 1);
  assign side_par = p_par[0];
  assign row_ch   = ROW_W'(p_cur);

  assign rd_l    = rd_data[2*ENTRY_W-1:ENTRY_W];
  assign rd_r    = rd_data[ENTRY_W-1:0];
  assign par_ent = side_par ? rd_r : rd_l;

  assign n_is_root = (n_r == NW'(1));
  assign up_less   = item_r[ENTRY_W-1 -: SEQ_WIDTH] < par_ent[ENTRY_W-1 -: SEQ_WIDTH];
  assign pop_hit   = (count_r != '0) && (rd_l[ENTRY_W-1 -: SEQ_WIDTH] == exp_r);
  assign dn_leaf   = {n_r[NW-2:0], 1'b0} > NW'(count_r);
  assign r_ok      = {n_r[NW-2:0], 1'b1} <= NW'(count_r);
  assign pick_l    = rd_l[ENTRY_W-1 -: SEQ_WIDTH] < item_r[ENTRY_W-1 -: SEQ_WIDTH];
  assign best_key  = pick_l ? rd_l[ENTRY_W-1 -: SEQ_WIDTH] : item_r[ENTRY_W-1 -: SEQ_WIDTH];
  assign pick_r    = r_ok && (rd_r[ENTRY_W-1 -: SEQ_WIDTH] < best_key);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mhpr_pkg::ST_IDLE: begin
        if (accept) begin
          if (!full) state_nxt = mhpr_pkg::ST_UP_RD;
          else if (rel_now) state_nxt = mhpr_pkg::ST_POP_RD;
        end
      end
      mhpr_pkg::ST_UP_RD: begin
        if (n_is_root) state_nxt = rel_r ? mhpr_pkg::ST_POP_RD : mhpr_pkg::ST_IDLE;
        else state_nxt = mhpr_pkg::ST_UP_CMP;
      end
      mhpr_pkg::ST_UP_CMP: begin
        if (up_less) state_nxt = mhpr_pkg::ST_UP_RD;
        else state_nxt = rel_r ? mhpr_pkg::ST_POP_RD : mhpr_pkg::ST_IDLE;
      end
      mhpr_pkg::ST_POP_RD:  state_nxt = mhpr_pkg::ST_POP_CHK;
      mhpr_pkg::ST_POP_CHK: begin
        if (!pop_hit) state_nxt = mhpr_pkg::ST_IDLE;
        else if (count_r == CW'(1)) state_nxt = mhpr_pkg::ST_POP_RD;
        else state_nxt = mhpr_pkg::ST_LAST_RD;
      end
      mhpr_pkg::ST_LAST_RD:  state_nxt = mhpr_pkg::ST_LAST_DAT;
      mhpr_pkg::ST_LAST_DAT: state_nxt = mhpr_pkg::ST_DN_RD;
      mhpr_pkg::ST_DN_RD: begin
        state_nxt = dn_leaf ? mhpr_pkg::ST_POP_RD : mhpr_pkg::ST_DN_CMP;
      end
      mhpr_pkg::ST_DN_CMP: begin
        state_nxt = (pick_l || pick_r) ? mhpr_pkg::ST_DN_RD : mhpr_pkg::ST_POP_RD;
      end
      default: state_nxt = mhpr_pkg::ST_IDLE;
    endcase
  end

  // datapath, cell commands and results
  always_comb begin
    count_nxt  = count_r;
    exp_nxt    = exp_r;
    fill_nxt   = fill_r;
    item_nxt   = item_r;
    n_nxt      = n_r;
    lvl_nxt    = lvl_r;
    rel_nxt    = rel_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    ov_nxt     = 1'b0;
    oent_nxt   = oent_r;
    olast_nxt  = 1'b0;
    oovf_nxt   = 1'b0;
    cmd        = '0;
    lvl_sel    = lvl_r;
    row        = row_cur;
    wdata      = item_r;
    unique case (state_r)
      mhpr_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt = {in_seq_number, in_payload_tag};
          rel_nxt  = rel_now;
          fill_nxt = rel_now ? '0 : fill_inc;
          if (full) begin
            ov_nxt   = 1'b1;
            oent_nxt = '0;
            oovf_nxt = 1'b1;
          end else begin
            count_nxt = count_inc;
            n_nxt     = NW'(count_inc);
            lvl_nxt   = msb_of(NW'(count_inc));
          end
        end
      end
      mhpr_pkg::ST_UP_RD: begin
        if (n_is_root) begin
          cmd.wr      = 1'b1;
          cmd.wr_side = side_cur;
        end else begin
          cmd.rd  = 1'b1;
          lvl_sel = lvl_r - 1'b1;
          row     = row_par;
        end
      end
      mhpr_pkg::ST_UP_CMP: begin
        cmd.wr      = 1'b1;
        cmd.wr_side = side_cur;
        if (up_less) begin
          wdata   = par_ent;
          n_nxt   = n_par;
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      mhpr_pkg::ST_POP_RD: begin
        cmd.rd  = 1'b1;
        lvl_sel = '0;
        row     = '0;
      end
      mhpr_pkg::ST_POP_CHK: begin
        if (pop_hit) begin
          if (pend_v_r) begin
            ov_nxt   = 1'b1;
            oent_nxt = pend_r;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = rd_l;
          exp_nxt    = exp_r + SEQ_WIDTH'(1);
          count_nxt  = count_r - CW'(1);
          n_nxt      = NW'(count_r);
          lvl_nxt    = msb_of(NW'(count_r));
        end else if (pend_v_r) begin
          // the held packet closes the run
          ov_nxt     = 1'b1;
          oent_nxt   = pend_r;
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      mhpr_pkg::ST_LAST_RD: begin
        cmd.rd = 1'b1;
      end
      mhpr_pkg::ST_LAST_DAT: begin
        item_nxt = side_cur ? rd_r : rd_l;
        n_nxt    = NW'(1);
        lvl_nxt  = '0;
      end
      mhpr_pkg::ST_DN_RD: begin
        if (dn_leaf) begin
          cmd.wr      = 1'b1;
          cmd.wr_side = side_cur;
        end else begin
          cmd.rd  = 1'b1;
          lvl_sel = lvl_r + 1'b1;
          row     = row_ch;
        end
      end
      mhpr_pkg::ST_DN_CMP: begin
        cmd.wr      = 1'b1;
        cmd.wr_side = side_cur;
        if (pick_r) begin
          wdata   = rd_r;
          n_nxt   = {n_r[NW-2:0], 1'b1};
          lvl_nxt = lvl_r + 1'b1;
        end else if (pick_l) begin
          wdata   = rd_l;
          n_nxt   = {n_r[NW-2:0], 1'b0};
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mhpr_pkg::ST_IDLE;
      count_r  <= '0;
      exp_r    <= '0;
      fill_r   <= '0;
      bsize_r  <= mhpr_pkg::BLOCK_SIZE_RST;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      exp_r    <= exp_nxt;
      fill_r   <= fill_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) bsize_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    n_r     <= n_nxt;
    lvl_r   <= lvl_nxt;
    rel_r   <= rel_nxt;
    pend_r  <= pend_nxt;
    oent_r  <= oent_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign out_valid    = ov_r;
  assign out_seq      = oent_r[ENTRY_W-1 -: SEQ_WIDTH];
  assign out_tag      = oent_r[TAG_WIDTH-1:0];
  assign out_run_last = olast_r;
  assign out_overflow = oovf_r;

endmodule

`default_nettype wire

// ===== sv/mhpr_checker.sv =====
// Port-level checks for min_heap_packet_reorder, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module mhpr_checker #(
  parameter int SEQ_WIDTH = 16,
  parameter int TAG_WIDTH = 32
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic [SEQ_WIDTH-1:0] out_seq,
  input wire logic [TAG_WIDTH-1:0] out_tag,
  input wire logic                 out_run_last,
  input wire logic                 out_overflow
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");

  a_accept_acts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted packet neither worked on nor reported");

  a_ovf_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_run_last && out_overflow))
    else $error("overflow result marked as run end");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_seq == '0 && out_tag == '0)
    else $error("overflow result carries packet data");

endmodule

bind min_heap_packet_reorder mhpr_checker #(
  .SEQ_WIDTH (SEQ_WIDTH),
  .TAG_WIDTH (TAG_WIDTH)
) u_mhpr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_seq      (out_seq),
  .out_tag      (out_tag),
  .out_run_last (out_run_last),
  .out_overflow (out_overflow)
);

`default_nettype wire

// ===== test/tb_min_heap_packet_reorder.sv =====
// Testbench for min_heap_packet_reorder: packets in, in-order releases checked
// against a heap predictor in a small scoreboard class. Depends on mhpr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_min_heap_packet_reorder;

  localparam int DEPTH = 32;
  localparam int LIMIT = 1000000;

  typedef struct {
    logic [15:0] seq;
    logic [31:0] tag;
    logic        last;
    logic        ovf;
  } release_t;

  class release_predictor;
    logic [15:0]                keys[DEPTH];
    logic [31:0]                tags[DEPTH];
    int unsigned                count;
    int unsigned                fill;
    logic [15:0]                next_seq;
    logic [mhpr_pkg::CFG_W-1:0] block_size;
    release_t                   expected_releases[$];
    int                         errors;
    int                         releases;
    int                         overflows;

    function new();
      count = 0;
      fill = 0;
      next_seq = 0;
      block_size = mhpr_pkg::BLOCK_SIZE_RST;
      errors = 0;
      releases = 0;
      overflows = 0;
    endfunction

    function void swap_slot(int a, int b);
      logic [15:0] k;
      logic [31:0] t;
      k = keys[a]; keys[a] = keys[b]; keys[b] = k;
      t = tags[a]; tags[a] = tags[b]; tags[b] = t;
    endfunction

    // Returns 1 when the packet was dropped on a full heap.
    function bit note_packet(logic [15:0] seq, logic [31:0] tag, bit eoi);
      int i, up, best, l, r, popped;
      int unsigned bs_eff;
      bit dropped;
      release_t rel;
      dropped = 0;
      popped = 0;
      if (count >= DEPTH) begin
        dropped = 1;
        rel.seq = '0; rel.tag = '0; rel.last = 0; rel.ovf = 1;
        expected_releases.push_back(rel);
      end else begin
        keys[count] = seq;
        tags[count] = tag;
        i = count;
        while (i > 0) begin
          up = (i - 1) / 2;
          if (keys[i] >= keys[up]) break;
          swap_slot(i, up);
          i = up;
        end
        count++;
      end
      fill = (fill + 1) & 6'h3f;
      bs_eff = (block_size == 0) ? 1 : block_size;
      if (fill >= bs_eff || eoi) begin
        fill = 0;
        while (count > 0 && keys[0] == next_seq) begin
          rel.seq = keys[0]; rel.tag = tags[0]; rel.last = 0; rel.ovf = 0;
          count--;
          keys[0] = keys[count];
          tags[0] = tags[count];
          i = 0;
          while (i < count) begin
            best = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < count && keys[l] < keys[best]) best = l;
            if (r < count && keys[r] < keys[best]) best = r;
            if (best == i) break;
            swap_slot(i, best);
            i = best;
          end
          expected_releases.push_back(rel);
          popped++;
          next_seq = next_seq + 16'd1;
        end
        // overflow entry always comes first, so the tail is a pop here
        if (popped > 0) expected_releases[$].last = 1;
      end
      return dropped;
    endfunction

    function void check_release(logic [15:0] seq, logic [31:0] tag, logic last, logic ovf);
      release_t e;
      if (expected_releases.size() == 0) begin
        $display("%0t: unexpected result seq=%h tag=%h last=%b ovf=%b",
                 $time, seq, tag, last, ovf);
        errors++;
        return;
      end
      e = expected_releases.pop_front();
      if (ovf) overflows++; else releases++;
      if (seq !== e.seq) begin
        $display("%0t: out_seq expected %h actual %h", $time, e.seq, seq);
        errors++;
      end
      if (tag !== e.tag) begin
        $display("%0t: out_tag expected %h actual %h", $time, e.tag, tag);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: out_run_last expected %b actual %b", $time, e.last, last);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: out_overflow expected %b actual %b", $time, e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 0;
  logic                       rst_n = 0;
  logic                       start = 0;
  logic                       busy;
  logic [15:0]                in_seq_number = '0;
  logic [31:0]                in_payload_tag = '0;
  logic                       in_end_of_input = 0;
  logic                       cfg_we = 0;
  logic [mhpr_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                       out_valid;
  logic [15:0]                out_seq;
  logic [31:0]                out_tag;
  logic                       out_run_last;
  logic                       out_overflow;

  release_predictor sb = new();
  logic [15:0]      pending[$];
  logic [15:0]      next_send = 0;
  int               noise_budget = 8;
  int               packets = 0;
  bit               idle_on = 1;

  min_heap_packet_reorder uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seq_number(in_seq_number), .in_payload_tag(in_payload_tag),
    .in_end_of_input(in_end_of_input), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_seq(out_seq), .out_tag(out_tag),
    .out_run_last(out_run_last), .out_overflow(out_overflow)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_release(out_seq, out_tag, out_run_last, out_overflow);
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("min_heap_packet_reorder: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_packet(input logic [15:0] seq, input logic [31:0] tag,
                             input bit eoi, input int gap, output bit dropped);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_seq_number <= seq;
    in_payload_tag <= tag;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (busy) @(posedge clk);
    dropped = sb.note_packet(seq, tag, eoi);
    packets++;
  endtask

  task automatic set_block_size(input logic [mhpr_pkg::CFG_W-1:0] value);
    start <= 0;
    @(posedge clk);
    while (sb.expected_releases.size() != 0) @(posedge clk);
    // a packet with no release may still be sifting
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.block_size = value;
  endtask

  task automatic refill(input int width);
    logic [15:0] win[$];
    logic [15:0] t;
    int j;
    for (int k = 0; k < width; k++) win.push_back(16'(next_send + k));
    for (int k = width - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = win[k]; win[k] = win[j]; win[j] = t;
    end
    foreach (win[k]) pending.push_back(win[k]);
    next_send = 16'(next_send + width);
  endtask

  task automatic send_next();
    logic [15:0] s;
    bit eoi, noise, dropped;
    noise = (noise_budget > 0) && ($urandom_range(0, 99) < 4);
    if (noise) begin
      // far-off or stale number: it stays in the heap for good
      s = 16'($urandom);
      eoi = 1;
      noise_budget--;
    end else begin
      if (pending.size() == 0) refill($urandom_range(1, 8));
      s = pending.pop_front();
      eoi = ($urandom_range(0, 9) == 0) || (sb.count >= 24);
    end
    send_packet(s, $urandom, eoi, pick_gap(), dropped);
    if (dropped && !noise) pending.push_back(s);
  endtask

  task automatic random_phase(input int n, input logic [mhpr_pkg::CFG_W-1:0] bs);
    set_block_size(bs);
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_next();
    end
  endtask

  initial begin
    bit dropped;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset block size, out-of-order pair released on end of input
    send_packet(16'd1, 32'hffffffff, 0, 0, dropped);
    send_packet(16'd0, 32'h00000000, 1, 0, dropped);
    // block size zero acts as one; empty run on a gap
    set_block_size(6'd0);
    send_packet(16'd3, $urandom, 0, 1, dropped);
    send_packet(16'd2, $urandom, 0, 0, dropped);
    send_packet(16'd5, $urandom, 0, 3, dropped);
    send_packet(16'd4, $urandom, 0, 0, dropped);
    next_send = 16'd6;

    // fill the heap, then overflow with end of input: drop plus a full run
    set_block_size(6'd63);
    refill(32);
    while (pending.size() != 0) send_packet(pending.pop_front(), $urandom, 0, pick_gap(), dropped);
    send_packet(next_send, $urandom, 1, 0, dropped);
    if (dropped) pending.push_back(next_send);
    next_send = next_send + 16'd1;

    // top key and a stale duplicate, both stuck in the heap
    set_block_size(6'd8);
    send_packet(16'hffff, $urandom, 1, 2, dropped);
    send_packet(16'd0, $urandom, 1, 0, dropped);

    random_phase(50, 6'd8);
    random_phase(30, 6'd1);
    random_phase(35, 6'd32);
    random_phase(25, 6'd0);
    random_phase(35, 6'd5);
    random_phase(35, 6'd63);

    start <= 0;
    @(posedge clk);
    while (sb.expected_releases.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d packets over six block sizes; %0d releases and %0d overflows checked.",
             packets, sb.releases, sb.overflows);
    if (sb.errors == 0) $display("min_heap_packet_reorder: match");
    else $display("min_heap_packet_reorder: mismatch");
    $finish;
  end

endmodule
